/* rtl/dvrt_pkg.sv */
// ----------------------------------------------------------------------------
// dvrt_pkg: shared definitions for the distance-vector route table
// Table geometry, field widths, command and status codes, and the row layout.
// ----------------------------------------------------------------------------
package dvrt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);

	localparam int ADDR_W    = 56;
	localparam int KEY_W     = 64;
	localparam int TIME_W    = 48;
	localparam int HOP_W     = 8;
	localparam int AGE_W     = 16;
	localparam int CNT_W     = 7;
	localparam int CMD_W     = 2;
	localparam int STAT_W    = 2;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CMD_W-1:0] CMD_ADV    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_HOP_LIMIT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HOPS  = 1'd1;

	localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 16'd3000;
	localparam logic [HOP_W-1:0] MAX_HOPS_RESET  = 8'd32;

	typedef struct packed {
		logic [ADDR_W-1:0] dest;
		logic [ADDR_W-1:0] next_hop;
		logic [HOP_W-1:0]  hops;
		logic [TIME_W-1:0] stamp;
	} row_t;

endpackage

/* rtl/distance_vector_route_table.sv */
// ----------------------------------------------------------------------------
// distance_vector_route_table: 64-slot distance-vector route table
// Advertise, lookup and age sweep over a row memory with one read and one write port.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word is taken at a clock edge with start high and busy
//   low. command selects advertise, lookup or age sweep; the other input
//   ports carry that word's fields and are sampled only at that edge.
//   Result channel: done is high for exactly one cycle per command word, with
//   found, next_hop, hop_count, status and removed_count valid in that cycle.
//   The receiver cannot stall; take the result when done is high.
//   Timing: every advertise, lookup and sweep reads the row memory once per
//   slot, one slot a cycle, then passes a drain state and a final state before
//   done rises; busy falls in that same cycle, so a new word may be started
//   while done is shown, but not before. An advertise over the hop limit and
//   an unknown command answer in the cycle after acceptance and leave busy low.
//   Configuration: cfg_wr_en writes cfg_data to register cfg_index (0: age
//   limit in ms, 1: hop limit) at the clock edge; write only while idle.
//   Reset: arst_n clears all valid bits, so the table starts empty, and loads
//   an age limit of 3000 ms and a hop limit of 32. No clearing pass is needed.
// ----------------------------------------------------------------------------
module distance_vector_route_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [dvrt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dvrt_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic [dvrt_pkg::CMD_W-1:0]        command,
	input  logic [dvrt_pkg::KEY_W-1:0]        adv_key,
	input  logic [dvrt_pkg::ADDR_W-1:0]       neighbor_addr,
	input  logic [dvrt_pkg::ADDR_W-1:0]       lookup_addr,
	input  logic [dvrt_pkg::TIME_W-1:0]       now_ms,
	output logic                              done,
	output logic                              found,
	output logic [dvrt_pkg::ADDR_W-1:0]       next_hop,
	output logic [dvrt_pkg::HOP_W-1:0]        hop_count,
	output logic [dvrt_pkg::STAT_W-1:0]       status,
	output logic [dvrt_pkg::CNT_W-1:0]        removed_count
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam logic [dvrt_pkg::IDX_W-1:0] LAST_IDX =
		dvrt_pkg::IDX_W'(dvrt_pkg::TABLE_ENTRIES - 1);

	// Row memory: one synchronous read port, one write port.
	dvrt_pkg::row_t mem [dvrt_pkg::TABLE_ENTRIES];

	logic [1:0]                          state_q;
	logic [dvrt_pkg::IDX_W-1:0]          rd_idx_q;
	logic                                vld_s1;
	logic [dvrt_pkg::IDX_W-1:0]          idx_s1;
	dvrt_pkg::row_t                      rd_row_s1;
	logic [dvrt_pkg::TABLE_ENTRIES-1:0]  valid_q;

	logic [dvrt_pkg::AGE_W-1:0]          age_limit_q;
	logic [dvrt_pkg::HOP_W-1:0]          max_hops_q;

	// Latched command word.
	logic [dvrt_pkg::CMD_W-1:0]          cmd_q;
	logic [dvrt_pkg::ADDR_W-1:0]         key_q;
	logic [dvrt_pkg::ADDR_W-1:0]         nbr_q;
	logic [dvrt_pkg::HOP_W-1:0]          hops_q;
	logic [dvrt_pkg::TIME_W-1:0]         now_q;

	// Scan results.
	logic                                hit_q;
	logic [dvrt_pkg::IDX_W-1:0]          hit_idx_q;
	dvrt_pkg::row_t                      hit_row_q;
	logic                                free_ok_q;
	logic [dvrt_pkg::IDX_W-1:0]          free_idx_q;
	logic [dvrt_pkg::CNT_W-1:0]          removed_q;

	// Result registers.
	logic                                done_q;
	logic                                found_q;
	logic [dvrt_pkg::ADDR_W-1:0]         next_hop_q;
	logic [dvrt_pkg::HOP_W-1:0]          hop_count_q;
	logic [dvrt_pkg::STAT_W-1:0]         status_q;
	logic [dvrt_pkg::CNT_W-1:0]          removed_count_q;

	logic                                accept;
	logic [dvrt_pkg::HOP_W:0]            adv_hops;
	logic                                over_limit;
	logic                                match_s1;
	logic                                aged_s1;
	logic                                better;
	logic                                no_worse;
	dvrt_pkg::row_t                      merged_row;
	dvrt_pkg::row_t                      new_row;
	dvrt_pkg::row_t                      wr_row;
	logic                                wr_en;
	logic [dvrt_pkg::IDX_W-1:0]          wr_idx;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Advertised count plus one, kept one bit wider so a count of 255 lands
	// above any hop limit instead of wrapping to zero.
	assign adv_hops   = {1'b0, adv_key[dvrt_pkg::KEY_W-1 -: dvrt_pkg::HOP_W]} +
		(dvrt_pkg::HOP_W+1)'(1);
	assign over_limit = adv_hops > {1'b0, max_hops_q};

	// Compare stage: row data arrives in the cycle after its read address.
	assign match_s1 = vld_s1 && valid_q[idx_s1] && (rd_row_s1.dest == key_q);
	assign aged_s1  = vld_s1 && valid_q[idx_s1] &&
		(({1'b0, rd_row_s1.stamp} + (dvrt_pkg::TIME_W+1)'(age_limit_q)) <
		 {1'b0, now_q});

	// Merge for a known destination: refresh when no worse, replace route
	// when strictly better.
	assign better   = hops_q <  hit_row_q.hops;
	assign no_worse = hops_q <= hit_row_q.hops;

	always_comb begin
		merged_row          = hit_row_q;
		if (better) begin
			merged_row.next_hop = nbr_q;
			merged_row.hops     = hops_q;
		end
		if (no_worse) begin
			merged_row.stamp    = now_q;
		end
		new_row.dest     = key_q;
		new_row.next_hop = nbr_q;
		new_row.hops     = hops_q;
		new_row.stamp    = now_q;
	end

	assign wr_en  = (state_q == ST_FIN) && (cmd_q == dvrt_pkg::CMD_ADV) &&
		(hit_q || free_ok_q);
	assign wr_idx = hit_q ? hit_idx_q : free_idx_q;
	assign wr_row = hit_q ? merged_row : new_row;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_row;
		end
		rd_row_s1 <= mem[rd_idx_q];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= dvrt_pkg::AGE_LIMIT_RESET;
			max_hops_q  <= dvrt_pkg::MAX_HOPS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dvrt_pkg::REG_AGE_LIMIT: age_limit_q <= cfg_data;
				dvrt_pkg::REG_MAX_HOPS:  max_hops_q  <= cfg_data[dvrt_pkg::HOP_W-1:0];
				default: ;
			endcase
		end
	end

	// Latch the command word and the first matching row.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			key_q  <= (command == dvrt_pkg::CMD_ADV) ?
				adv_key[dvrt_pkg::ADDR_W-1:0] : lookup_addr;
			nbr_q  <= neighbor_addr;
			hops_q <= adv_hops[dvrt_pkg::HOP_W-1:0];
			now_q  <= now_ms;
		end
		if (match_s1 && !hit_q) begin
			hit_row_q <= rd_row_s1;
		end
	end

	// Sequencer, scan bookkeeping and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			rd_idx_q        <= '0;
			vld_s1          <= 1'b0;
			idx_s1          <= '0;
			valid_q         <= '0;
			hit_q           <= 1'b0;
			hit_idx_q       <= '0;
			free_ok_q       <= 1'b0;
			free_idx_q      <= '0;
			removed_q       <= '0;
			done_q          <= 1'b0;
			found_q         <= 1'b0;
			next_hop_q      <= '0;
			hop_count_q     <= '0;
			status_q        <= dvrt_pkg::STAT_DONE;
			removed_count_q <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == ST_SCAN);
			idx_s1 <= rd_idx_q;

			// Compare stage, shared by all three commands.
			if (match_s1 && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
			end
			if (aged_s1 && (cmd_q == dvrt_pkg::CMD_SWEEP)) begin
				valid_q[idx_s1] <= 1'b0;
				if (removed_q != '1) begin
					removed_q <= removed_q + dvrt_pkg::CNT_W'(1);
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					if (accept) begin
						hit_q     <= 1'b0;
						free_ok_q <= 1'b0;
						removed_q <= '0;
						case (command)
							dvrt_pkg::CMD_ADV: begin
								if (over_limit) begin
									// Drop without touching the table.
									done_q          <= 1'b1;
									found_q         <= 1'b0;
									next_hop_q      <= '0;
									hop_count_q     <= '0;
									status_q        <= dvrt_pkg::STAT_HOP_LIMIT;
									removed_count_q <= '0;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							dvrt_pkg::CMD_LOOKUP,
							dvrt_pkg::CMD_SWEEP: begin
								state_q <= ST_SCAN;
							end
							default: begin
								// Unknown command: answer with all fields zero.
								done_q          <= 1'b1;
								found_q         <= 1'b0;
								next_hop_q      <= '0;
								hop_count_q     <= '0;
								status_q        <= dvrt_pkg::STAT_DONE;
								removed_count_q <= '0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// Track the lowest free slot on the read side.
					if (!valid_q[rd_idx_q] && !free_ok_q) begin
						free_ok_q  <= 1'b1;
						free_idx_q <= rd_idx_q;
					end
					if (rd_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + dvrt_pkg::IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q         <= ST_IDLE;
					done_q          <= 1'b1;
					found_q         <= 1'b0;
					next_hop_q      <= '0;
					hop_count_q     <= '0;
					status_q        <= dvrt_pkg::STAT_DONE;
					removed_count_q <= '0;
					case (cmd_q)
						dvrt_pkg::CMD_ADV: begin
							if (!hit_q) begin
								if (free_ok_q) begin
									valid_q[free_idx_q] <= 1'b1;
								end else begin
									status_q <= dvrt_pkg::STAT_FULL;
								end
							end
						end
						dvrt_pkg::CMD_LOOKUP: begin
							if (hit_q) begin
								found_q     <= 1'b1;
								next_hop_q  <= hit_row_q.next_hop;
								hop_count_q <= hit_row_q.hops;
							end
						end
						dvrt_pkg::CMD_SWEEP: begin
							removed_count_q <= removed_q;
						end
						default: ;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done          = done_q;
	assign found         = found_q;
	assign next_hop      = next_hop_q;
	assign hop_count     = hop_count_q;
	assign status        = status_q;
	assign removed_count = removed_count_q;

endmodule

/* rtl/dvrt_chk.sv */
// ----------------------------------------------------------------------------
// dvrt_chk: port-level checks for the distance-vector route table
// Watches the command and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module dvrt_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic                              done,
	input  logic                              found,
	input  logic [dvrt_pkg::ADDR_W-1:0]       next_hop,
	input  logic [dvrt_pkg::HOP_W-1:0]        hop_count,
	input  logic [dvrt_pkg::STAT_W-1:0]       status,
	input  logic [dvrt_pkg::CNT_W-1:0]        removed_count
);

	// A result word follows either a word taken while idle or a running scan.
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result word without a command word");

	// A scan ends only by delivering its result.
	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result word");

	// Route fields are zero unless a lookup hit.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (next_hop == '0) && (hop_count == '0))
		else $error("route fields set without a hit");

	// A drop status never comes with a hit or a removal count.
	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != dvrt_pkg::STAT_DONE)) |->
			(!found && (removed_count == '0) &&
			 ((status == dvrt_pkg::STAT_HOP_LIMIT) || (status == dvrt_pkg::STAT_FULL))))
		else $error("bad drop status word");

	// A result word is only shown while the block is idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while busy");

endmodule

bind distance_vector_route_table dvrt_chk u_dvrt_chk (.*);
